[rtl/point_to_segment_projection_core_assert.svh]
// assertion macros for the point to segment projection core
// no dependencies; included by the files that hold assertions
`ifndef POINT_TO_SEGMENT_PROJECTION_CORE_ASSERT_SVH
`define POINT_TO_SEGMENT_PROJECTION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PTSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PTSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define PTSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/ptsp_pkg.sv]
// shared types and constants for the point to segment projection core
// no dependencies
package ptsp_pkg;

    localparam int COORD_WIDTH         = 24;
    localparam int DELTA_WIDTH         = COORD_WIDTH + 1;
    localparam int SUM_WIDTH           = 2 * DELTA_WIDTH;
    localparam int DIST_WIDTH          = 50;
    localparam int RATIO_FRAC_BITS_DEF = 24;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DELTA_WIDTH-1:0] delta_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t end_x;
        coord_t end_y;
        coord_t end_z;
        logic   only_on_segment;
    } req_t;

    typedef struct packed {
        coord_t                seg_point_x;
        coord_t                seg_point_y;
        coord_t                seg_point_z;
        coord_t                line_point_x;
        coord_t                line_point_y;
        coord_t                line_point_z;
        logic                  on_segment;
        logic [DIST_WIDTH-1:0] dist_squared;
        logic                  dist_valid;
        logic                  degenerate;
    } resp_t;

    // per-request data riding alongside the divider chain
    typedef struct packed {
        coord_t [2:0] p;
        coord_t [2:0] s;
        delta_t [2:0] d;
        logic         only;
        logic         dneg;
        logic         degen;
        logic         cap;
    } side_t;

endpackage

[rtl/ptsp_div_cell.sv]
// one restoring division cell: produces one quotient bit per request
// depends on nothing; chained by point_to_segment_projection_core
module ptsp_div_cell #(
    parameter int REM_W  = 50,
    parameter int QW     = 50,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              up_valid,
    input  logic [REM_W-1:0]  up_rem,
    input  logic [QW-1:0]     up_num,
    input  logic [QW-1:0]     up_quo,
    input  logic [REM_W-1:0]  up_den,
    input  logic [SIDE_W-1:0] up_side,
    output logic              dn_valid,
    output logic [REM_W-1:0]  dn_rem,
    output logic [QW-1:0]     dn_num,
    output logic [QW-1:0]     dn_quo,
    output logic [REM_W-1:0]  dn_den,
    output logic [SIDE_W-1:0] dn_side
);

    logic              valid_reg;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QW-1:0]     num_reg, quo_reg;
    logic [REM_W-1:0]  den_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [REM_W:0]    trial, diff;
    logic              ge;

    // shift in next numerator bit, subtract when it fits
    always_comb
    begin
        trial    = {up_rem, up_num[QW-1]};
        diff     = trial - {1'b0, up_den};
        ge       = (trial >= {1'b0, up_den});
        rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            num_reg  <= {up_num[QW-2:0], 1'b0};
            quo_reg  <= {up_quo[QW-2:0], ge};
            den_reg  <= up_den;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_num   = num_reg;
    assign dn_quo   = quo_reg;
    assign dn_den   = den_reg;
    assign dn_side  = side_reg;

endmodule

[rtl/point_to_segment_projection_core.sv]
// top level of the point to segment projection core
// depends on ptsp_pkg, ptsp_div_cell and point_to_segment_projection_core_assert.svh
//
// Projects a 3D point onto a segment, one request per cycle, fully pipelined.
// Stages a, b and c form the dot product and squared length, a chain of
// RATIO_FRAC_BITS + COORD_WIDTH + 2 division cells yields one ratio bit each,
// and stages e, f, g, h and the output register clamp, project and form the
// squared distance. The whole pipeline stalls only while a result waits at
// the output register.
`include "point_to_segment_projection_core_assert.svh"
module point_to_segment_projection_core #(
    parameter int RATIO_FRAC_BITS = ptsp_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ptsp_pkg::req_t  req_data,
    output logic            resp_valid,
    input  logic            resp_ready,
    output ptsp_pkg::resp_t resp_data
);

    localparam int CW     = ptsp_pkg::COORD_WIDTH;
    localparam int DW     = ptsp_pkg::DELTA_WIDTH;
    localparam int SW     = ptsp_pkg::SUM_WIDTH;
    localparam int RF     = RATIO_FRAC_BITS;
    localparam int QW     = CW + 2 + RF;
    localparam int LH     = (QW + 1) / 2;
    localparam int HH     = QW - LH;
    localparam int LPW    = QW + DW;
    localparam int LW     = 2 * CW + 5;
    localparam int NW     = SW + CW + 2;
    localparam int DSTW   = ptsp_pkg::DIST_WIDTH;
    localparam int EW     = (SW > DSTW) ? SW + 1 : DSTW + 1;
    localparam int SIDE_W = $bits(ptsp_pkg::side_t);
    localparam logic [QW-1:0] RMAX  = {1'b1, {(QW-1){1'b0}}};
    localparam logic [QW-1:0] ONE_Q = {{(QW-RF-1){1'b0}}, 1'b1, {RF{1'b0}}};

    // saturate a wide signed value to the coordinate range
    function automatic ptsp_pkg::coord_t sat_coord(input logic signed [LW-1:0] v);
        logic hi_zero;
        logic hi_ones;
        hi_zero = (v[LW-1:CW-1] == '0);
        hi_ones = (v[LW-1:CW-1] == '1);
        if (hi_zero || hi_ones)
            sat_coord = v[CW-1:0];
        else if (v[LW-1])
            sat_coord = {1'b1, {(CW-1){1'b0}}};
        else
            sat_coord = {1'b0, {(CW-1){1'b1}}};
    endfunction

    logic adv;
    assign adv       = !resp_valid || resp_ready;
    assign req_ready = adv;

    // request fields as lanes
    ptsp_pkg::coord_t in_p [3];
    ptsp_pkg::coord_t in_s [3];
    ptsp_pkg::coord_t in_e [3];
    always_comb
    begin
        in_p[0] = req_data.point_x;
        in_p[1] = req_data.point_y;
        in_p[2] = req_data.point_z;
        in_s[0] = req_data.start_x;
        in_s[1] = req_data.start_y;
        in_s[2] = req_data.start_z;
        in_e[0] = req_data.end_x;
        in_e[1] = req_data.end_y;
        in_e[2] = req_data.end_z;
    end

    // stage a: deltas
    logic             a_v_reg;
    ptsp_pkg::coord_t a_p_reg [3];
    ptsp_pkg::coord_t a_s_reg [3];
    ptsp_pkg::delta_t a_d_reg [3];
    ptsp_pkg::delta_t a_pd_reg [3];
    logic             a_only_reg;

    // stage b: products
    logic                    b_v_reg;
    ptsp_pkg::coord_t        b_p_reg [3];
    ptsp_pkg::coord_t        b_s_reg [3];
    ptsp_pkg::delta_t        b_d_reg [3];
    logic signed [SW-1:0]    b_dot_reg [3];
    logic signed [SW-1:0]    b_len_reg [3];
    logic                    b_only_reg;

    // stage c: dot magnitude and squared length
    logic             c_v_reg;
    ptsp_pkg::coord_t c_p_reg [3];
    ptsp_pkg::coord_t c_s_reg [3];
    ptsp_pkg::delta_t c_d_reg [3];
    logic [SW-1:0]    c_dmag_reg;
    logic [SW-1:0]    c_len_reg;
    logic             c_dneg_reg;
    logic             c_only_reg;
    logic signed [SW:0] dot_next;

    always_comb
    begin
        dot_next = {b_dot_reg[0][SW-1], b_dot_reg[0]}
                 + {b_dot_reg[1][SW-1], b_dot_reg[1]}
                 + {b_dot_reg[2][SW-1], b_dot_reg[2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= req_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_p_reg[i]   <= in_p[i];
                a_s_reg[i]   <= in_s[i];
                a_d_reg[i]   <= DW'(in_e[i]) - DW'(in_s[i]);
                a_pd_reg[i]  <= DW'(in_p[i]) - DW'(in_s[i]);
                b_p_reg[i]   <= a_p_reg[i];
                b_s_reg[i]   <= a_s_reg[i];
                b_d_reg[i]   <= a_d_reg[i];
                b_dot_reg[i] <= a_pd_reg[i] * a_d_reg[i];
                b_len_reg[i] <= a_d_reg[i] * a_d_reg[i];
                c_p_reg[i]   <= b_p_reg[i];
                c_s_reg[i]   <= b_s_reg[i];
                c_d_reg[i]   <= b_d_reg[i];
            end
            a_only_reg <= req_data.only_on_segment;
            b_only_reg <= a_only_reg;
            c_only_reg <= b_only_reg;
            c_dneg_reg <= dot_next[SW];
            c_dmag_reg <= dot_next[SW] ? SW'(-dot_next) : dot_next[SW-1:0];
            c_len_reg  <= $unsigned(b_len_reg[0]) + $unsigned(b_len_reg[1])
                        + $unsigned(b_len_reg[2]);
        end
    end

    // divider chain entry
    logic                cell_v    [QW+1];
    logic [SW-1:0]       cell_rem  [QW+1];
    logic [QW-1:0]       cell_num  [QW+1];
    logic [QW-1:0]       cell_quo  [QW+1];
    logic [SW-1:0]       cell_den  [QW+1];
    logic [SIDE_W-1:0]   cell_side [QW+1];
    logic [QW:0]         cell_v_vec;
    ptsp_pkg::side_t     side_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            side_in.p[i] = c_p_reg[i];
            side_in.s[i] = c_s_reg[i];
            side_in.d[i] = c_d_reg[i];
        end
        side_in.only  = c_only_reg;
        side_in.dneg  = c_dneg_reg;
        side_in.degen = (c_len_reg == '0);
        side_in.cap   = ({{(NW-SW){1'b0}}, c_dmag_reg} >= {c_len_reg, {(CW+2){1'b0}}});
        cell_v[0]    = c_v_reg;
        cell_rem[0]  = {{(SW-CW){1'b0}}, c_dmag_reg[SW-1:CW+2]};
        cell_num[0]  = {c_dmag_reg[CW+1:0], {RF{1'b0}}};
        cell_quo[0]  = '0;
        cell_den[0]  = c_len_reg;
        cell_side[0] = side_in;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_cell
        ptsp_div_cell #(
            .REM_W  (SW),
            .QW     (QW),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .up_valid (cell_v[k]),
            .up_rem   (cell_rem[k]),
            .up_num   (cell_num[k]),
            .up_quo   (cell_quo[k]),
            .up_den   (cell_den[k]),
            .up_side  (cell_side[k]),
            .dn_valid (cell_v[k+1]),
            .dn_rem   (cell_rem[k+1]),
            .dn_num   (cell_num[k+1]),
            .dn_quo   (cell_quo[k+1]),
            .dn_den   (cell_den[k+1]),
            .dn_side  (cell_side[k+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i <= QW; i++)
            cell_v_vec[i] = cell_v[i];
    end

    // stage e: cap, sign and clamp of the ratio
    ptsp_pkg::side_t side_out;
    logic [QW-1:0]   ratio_next;
    logic            rneg_next;
    logic            onseg_next;
    logic [RF:0]     rs_next;

    always_comb
    begin
        side_out = ptsp_pkg::side_t'(cell_side[QW]);
        if (side_out.degen)
            ratio_next = '0;
        else if (side_out.cap || cell_quo[QW] > RMAX)
            ratio_next = RMAX;
        else
            ratio_next = cell_quo[QW];
        rneg_next  = side_out.dneg && (ratio_next != '0);
        onseg_next = !rneg_next && (ratio_next <= ONE_Q);
        if (rneg_next)
            rs_next = '0;
        else if (ratio_next > ONE_Q)
            rs_next = ONE_Q[RF:0];
        else
            rs_next = ratio_next[RF:0];
    end

    logic             e_v_reg;
    logic [QW-1:0]    e_ratio_reg;
    logic [RF:0]      e_rs_reg;
    logic             e_rneg_reg;
    logic             e_onseg_reg;
    ptsp_pkg::side_t  e_side_reg;

    // stage f: partial products of the projections
    logic             f_v_reg;
    logic [RF+DW:0]   f_seg_reg [3];
    logic [LH+DW-1:0] f_llo_reg [3];
    logic [HH+DW-1:0] f_lhi_reg [3];
    logic             f_rneg_reg;
    logic             f_onseg_reg;
    ptsp_pkg::side_t  f_side_reg;
    logic [DW-1:0]    dmag [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dmag[i] = e_side_reg.d[i][DW-1] ? DW'(-e_side_reg.d[i]) : e_side_reg.d[i];
    end

    // stage g: offsets and saturation
    logic               g_v_reg;
    ptsp_pkg::coord_t   g_lp_reg [3];
    ptsp_pkg::coord_t   g_sp_reg [3];
    ptsp_pkg::coord_t   g_p_reg [3];
    logic               g_onseg_reg;
    logic               g_only_reg;
    logic               g_degen_reg;
    logic [LPW-1:0]     lfull [3];
    logic signed [LW-1:0] loff [3];
    logic signed [LW-1:0] soff [3];
    logic signed [LW-1:0] sext [3];
    ptsp_pkg::coord_t   lp_next [3];
    ptsp_pkg::coord_t   sp_next [3];
    logic               dsign [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lfull[i]   = {f_lhi_reg[i], {LH{1'b0}}} + LPW'(f_llo_reg[i]);
            loff[i]    = LW'(lfull[i][LPW-1:RF]);
            soff[i]    = LW'(f_seg_reg[i][RF+DW:RF]);
            sext[i]    = {{(LW-CW){f_side_reg.s[i][CW-1]}}, f_side_reg.s[i]};
            dsign[i]   = f_side_reg.d[i][DW-1];
            lp_next[i] = sat_coord((f_rneg_reg != dsign[i]) ? sext[i] - loff[i]
                                                             : sext[i] + loff[i]);
            sp_next[i] = sat_coord(dsign[i] ? sext[i] - soff[i] : sext[i] + soff[i]);
        end
    end

    // stage h: squared deltas
    logic                 h_v_reg;
    logic signed [SW-1:0] h_sq_reg [3];
    ptsp_pkg::coord_t     h_lp_reg [3];
    ptsp_pkg::coord_t     h_sp_reg [3];
    logic                 h_onseg_reg;
    logic                 h_only_reg;
    logic                 h_degen_reg;
    ptsp_pkg::delta_t     err [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            err[i] = DW'(g_p_reg[i]) - DW'(g_sp_reg[i]);
    end

    // output stage: distance sum and invalid marking
    logic                 out_v_reg;
    ptsp_pkg::resp_t      out_reg, out_next;
    logic [EW-1:0]        dsum;
    logic                 dvalid;

    always_comb
    begin
        dsum   = EW'($unsigned(h_sq_reg[0])) + EW'($unsigned(h_sq_reg[1]))
               + EW'($unsigned(h_sq_reg[2]));
        dvalid = h_onseg_reg || !h_only_reg;
        out_next.seg_point_x  = h_sp_reg[0];
        out_next.seg_point_y  = h_sp_reg[1];
        out_next.seg_point_z  = h_sp_reg[2];
        out_next.line_point_x = h_lp_reg[0];
        out_next.line_point_y = h_lp_reg[1];
        out_next.line_point_z = h_lp_reg[2];
        out_next.on_segment   = h_onseg_reg;
        out_next.dist_valid   = dvalid;
        out_next.degenerate   = h_degen_reg;
        if (!dvalid || dsum > EW'({DSTW{1'b1}}))
            out_next.dist_squared = '1;
        else
            out_next.dist_squared = dsum[DSTW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg   <= 1'b0;
            f_v_reg   <= 1'b0;
            g_v_reg   <= 1'b0;
            h_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_v_reg   <= cell_v[QW];
            f_v_reg   <= e_v_reg;
            g_v_reg   <= f_v_reg;
            h_v_reg   <= g_v_reg;
            out_v_reg <= h_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_ratio_reg <= ratio_next;
            e_rs_reg    <= rs_next;
            e_rneg_reg  <= rneg_next;
            e_onseg_reg <= onseg_next;
            e_side_reg  <= side_out;
            for (int i = 0; i < 3; i++)
            begin
                f_seg_reg[i] <= e_rs_reg * dmag[i];
                f_llo_reg[i] <= e_ratio_reg[LH-1:0] * dmag[i];
                f_lhi_reg[i] <= e_ratio_reg[QW-1:LH] * dmag[i];
                g_lp_reg[i]  <= lp_next[i];
                g_sp_reg[i]  <= sp_next[i];
                g_p_reg[i]   <= f_side_reg.p[i];
                h_sq_reg[i]  <= err[i] * err[i];
                h_lp_reg[i]  <= g_lp_reg[i];
                h_sp_reg[i]  <= g_sp_reg[i];
            end
            f_rneg_reg  <= e_rneg_reg;
            f_onseg_reg <= e_onseg_reg;
            f_side_reg  <= e_side_reg;
            g_onseg_reg <= f_onseg_reg;
            g_only_reg  <= f_side_reg.only;
            g_degen_reg <= f_side_reg.degen;
            h_onseg_reg <= g_onseg_reg;
            h_only_reg  <= g_only_reg;
            h_degen_reg <= g_degen_reg;
            out_reg     <= out_next;
        end
    end

    assign resp_valid = out_v_reg;
    assign resp_data  = out_reg;

    // checks
    `PTSP_ASSERT_NOW(a_degen_on_seg, clk, rst_n, resp_valid && resp_data.degenerate,
        resp_data.on_segment && resp_data.dist_valid, "degenerate segment not on segment")
    `PTSP_ASSERT_NOW(a_invalid_ones, clk, rst_n, resp_valid && !resp_data.dist_valid,
        resp_data.dist_squared == '1, "invalid distance not all ones")
    `PTSP_ASSERT_NOW(a_onseg_match, clk, rst_n, resp_valid && resp_data.on_segment,
        resp_data.seg_point_x == resp_data.line_point_x &&
        resp_data.seg_point_y == resp_data.line_point_y &&
        resp_data.seg_point_z == resp_data.line_point_z, "on-segment points differ")
    `PTSP_ASSERT_NEXT(a_stall_hold, clk, rst_n, resp_valid && !resp_ready,
        $stable({a_v_reg, b_v_reg, c_v_reg, cell_v_vec, e_v_reg, f_v_reg, g_v_reg,
        h_v_reg}), "pipeline moved during stall")

endmodule
